[hw/rtl/rsi_pkg.sv]
// Shared widths, register indexes and latency functions for the ray/sphere intersect core.
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int M1_W       = 66;
    localparam int QUAD_W     = 68;
    localparam int DISC_W     = 136;
    localparam int ROOT1_W    = 68;
    localparam int NUM_W      = 86;
    localparam int DIVA_W     = 64;
    localparam int T_W        = 87;
    localparam int PROD3_W    = 120;
    localparam int NRM_W      = 121;
    localparam int NSQ_W      = 242;
    localparam int SUM_W      = 244;
    localparam int LEN_W      = 122;
    localparam int NDIV_W     = 135;
    localparam int NQ_W       = 15;
    localparam int NOUT_W     = 16;
    localparam int DIST_W     = 32;
    localparam int RAD_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_W       = 6 * COORD_W;
    localparam int OUT_W      = DIST_W + 3 * NOUT_W;

    localparam int DEF_W      = 32;
    localparam int DEF_DEPTH  = 1;

    localparam logic [RAD_W-1:0] RADIUS_RESET  = RAD_W'(65536);
    localparam logic [RAD_W-1:0] MIN_DIST_RESET = RAD_W'(66);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_MIN_DIST = 3'd4
    } cfg_reg_t;

    function automatic int mul_lat(input int aw, input int bw);
        return ((aw + 31) >> 5) * ((bw + 31) >> 5) + 2;
    endfunction

    function automatic int sqrt_lat(input int w);
        return w >> 1;
    endfunction

    function automatic int div_lat(input int qw);
        return qw + 2;
    endfunction

endpackage

[hw/rtl/rsi_delay.sv]
// Stall-aware delay line that carries side data alongside the arithmetic units.
`timescale 1ns / 1ps

module rsi_delay
    import rsi_pkg::*;
#(
    parameter int W     = DEF_W,
    parameter int DEPTH = DEF_DEPTH
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

[hw/rtl/rsi_mul.sv]
// Pipelined signed multiplier, one 32x32 partial product per stage.
`timescale 1ns / 1ps

module rsi_mul
    import rsi_pkg::*;
#(
    parameter int AW = DEF_W,
    parameter int BW = DEF_W
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int NS = NA * NB;
    localparam int FW = 32 * (NA + NB);
    localparam int PW = AW + BW;

    logic [32*NA-1:0] am_reg  [0:NS];
    logic [32*NB-1:0] bm_reg  [0:NS];
    logic [FW-1:0]    acc_reg [0:NS];
    logic             neg_reg [0:NS];
    logic signed [PW-1:0] p_reg;

    logic [AW-1:0] a_abs;
    logic [BW-1:0] b_abs;

    assign a_abs = a[AW-1] ? AW'(-a) : AW'(a);
    assign b_abs = b[BW-1] ? BW'(-b) : BW'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg[0]  <= (32*NA)'(a_abs);
            bm_reg[0]  <= (32*NB)'(b_abs);
            acc_reg[0] <= '0;
            neg_reg[0] <= a[AW-1] ^ b[BW-1];
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        localparam int I = (k - 1) / NB;
        localparam int J = (k - 1) % NB;
        logic [63:0]   prod;
        logic [FW-1:0] pp;

        always_comb
        begin
            prod = am_reg[k-1][32*I +: 32] * bm_reg[k-1][32*J +: 32];
            pp   = FW'(prod) << (32 * (I + J));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                am_reg[k]  <= am_reg[k-1];
                bm_reg[k]  <= bm_reg[k-1];
                acc_reg[k] <= acc_reg[k-1] + pp;
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_reg[NS] ? -$signed(PW'(acc_reg[NS])) : $signed(PW'(acc_reg[NS]));
        end
    end

    assign p = p_reg;

endmodule

[hw/rtl/rsi_sqrt.sv]
// Pipelined restoring floor square root, one root bit per stage.
`timescale 1ns / 1ps

module rsi_sqrt
    import rsi_pkg::*;
#(
    parameter int W = DEF_W
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   x,
    output logic [W/2-1:0] r
);

    localparam int HW = W / 2;
    localparam int RW = HW + 2;

    logic [RW-1:0] rem_reg  [1:HW];
    logic [HW-1:0] root_reg [1:HW];
    logic [W-1:0]  xs_reg   [1:HW];

    for (genvar k = 1; k <= HW; k++)
    begin : g_stage
        logic [RW-1:0]   rem_in;
        logic [HW-1:0]   root_in;
        logic [W-1:0]    xs_in;
        logic [RW+1:0]   cur;
        logic [RW+1:0]   trial;
        logic            ge;

        if (k == 1)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign xs_in   = x;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign xs_in   = xs_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in, xs_in[W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? RW'(cur - trial) : RW'(cur);
                root_reg[k] <= {root_in[HW-2:0], ge};
                xs_reg[k]   <= {xs_in[W-3:0], 2'b00};
            end
        end
    end

    assign r = root_reg[HW];

endmodule

[hw/rtl/rsi_div.sv]
// Pipelined signed-by-unsigned divider, one quotient bit per stage, floor or truncate.
`timescale 1ns / 1ps

module rsi_div
    import rsi_pkg::*;
#(
    parameter int   NW    = DEF_W,
    parameter int   DW    = DEF_W,
    parameter int   QW    = DEF_W,
    parameter logic FLOOR = 1'b0
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [NW-1:0] n,
    input  logic [DW-1:0]       d,
    output logic signed [QW:0]  q
);

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] lo_reg  [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [DW-1:0] dv_reg  [0:QW];
    logic          neg_reg [0:QW];
    logic signed [QW:0] q_out_reg;

    logic [NW-1:0] mag;

    assign mag = n[NW-1] ? NW'(-n) : NW'(n);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(mag >> QW);
            lo_reg[0]  <= mag[QW-1:0];
            q_reg[0]   <= '0;
            dv_reg[0]  <= d;
            neg_reg[0] <= n[NW-1];
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DW:0] cur;
        logic        ge;

        always_comb
        begin
            cur = {rem_reg[k-1], lo_reg[k-1][QW-1]};
            ge  = (cur >= {1'b0, dv_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DW'(cur - {1'b0, dv_reg[k-1]}) : DW'(cur);
                lo_reg[k]  <= lo_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                dv_reg[k]  <= dv_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    logic [QW:0] qx;
    logic        inc;

    always_comb
    begin
        qx  = {1'b0, q_reg[QW]};
        inc = FLOOR && (rem_reg[QW] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_out_reg <= neg_reg[QW] ? -$signed(qx + (QW+1)'(inc)) : $signed(qx);
        end
    end

    assign q = q_out_reg;

endmodule

[hw/rtl/ray_sphere_intersect_core.sv]
// Top level of the ray/sphere intersect core: config registers, schedule and output stage.
//
// Input stream s_*: one ray per transfer, origin and direction in signed Q16.16.
// Output stream m_*: one result per ray, hit flag in m_tuser, distance (unsigned
// Q16.16, saturated) and unit normal (signed Q1.14) in m_tdata; zeros on a miss.
// Config port: cfg_we/cfg_index/cfg_data write the sphere center, radius and
// minimum distance; write only while no ray is in flight.
// Throughput: one ray per cycle while the receiver does not stall. The time from input
// transfer to the result appearing on m_* is set by the chain of bit-per-stage units: the
// discriminant square root (68 stages), the distance dividers (88), the normal
// length square root (122) and the normal dividers (17), plus the multiplier
// pipelines around them.
// Reset clears all pipeline valid bits and loads the register reset values.
// When the receiver stalls with a result pending, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module ray_sphere_intersect_core
    import rsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // distance, normal_x, normal_y, normal_z
    output logic [OUT_W-1:0]      m_tdata,
    // hit
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LM1 = mul_lat(DIFF_W, DIFF_W);
    localparam int LM2 = mul_lat(QUAD_W, QUAD_W);
    localparam int LS1 = sqrt_lat(DISC_W);
    localparam int LD1 = div_lat(NUM_W);
    localparam int LM3 = mul_lat(DIFF_W, T_W);
    localparam int LM4 = mul_lat(NRM_W, NRM_W);
    localparam int LS2 = sqrt_lat(SUM_W);
    localparam int LD2 = div_lat(NQ_W);

    localparam int T1  = 1;
    localparam int T2  = T1 + LM1;
    localparam int T3  = T2 + 1;
    localparam int T4  = T3 + LM2;
    localparam int T5  = T4 + 1;
    localparam int T6  = T5 + LS1;
    localparam int T7  = T6 + 1;
    localparam int T8  = T7 + LD1;
    localparam int T9  = T8 + 1;
    localparam int T10 = T9 + LM3;
    localparam int T11 = T10 + 1;
    localparam int T12 = T11 + LM4;
    localparam int T13 = T12 + 1;
    localparam int T14 = T13 + LS2;
    localparam int T15 = T14 + LD2;
    localparam int LAT = T15 + 1;

    logic signed [COORD_W-1:0] center_reg [3];
    logic [RAD_W-1:0]          radius_reg;
    logic [RAD_W-1:0]          min_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADIUS_RESET;
            min_dist_reg  <= MIN_DIST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_reg[0] <= cfg_data;
                REG_CENTER_Y: center_reg[1] <= cfg_data;
                REG_CENTER_Z: center_reg[2] <= cfg_data;
                REG_RADIUS:   radius_reg    <= cfg_data[RAD_W-1:0];
                REG_MIN_DIST: min_dist_reg  <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // offset and direction
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] dir_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= DIFF_W'($signed(s_tdata[COORD_W*i +: COORD_W]))
                             - DIFF_W'(center_reg[i]);
                dir_reg[i]  <= DIFF_W'($signed(s_tdata[COORD_W*(3+i) +: COORD_W]));
            end
        end
    end

    // quadratic terms
    logic signed [M1_W-1:0] pa [3];
    logic signed [M1_W-1:0] ph [3];
    logic signed [M1_W-1:0] pc [3];
    logic signed [M1_W-1:0] prr;
    logic signed [DIFF_W-1:0] rad_s;

    assign rad_s = $signed({2'b00, radius_reg});

    for (genvar i = 0; i < 3; i++)
    begin : g_m1
        rsi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_aa
        (
            .clk (clk), .en (en), .a (dir_reg[i]), .b (dir_reg[i]), .p (pa[i])
        );
        rsi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_hh
        (
            .clk (clk), .en (en), .a (diff_reg[i]), .b (dir_reg[i]), .p (ph[i])
        );
        rsi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_cc
        (
            .clk (clk), .en (en), .a (diff_reg[i]), .b (diff_reg[i]), .p (pc[i])
        );
    end

    rsi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_rr
    (
        .clk (clk), .en (en), .a (rad_s), .b (rad_s), .p (prr)
    );

    logic signed [QUAD_W-1:0] a_reg;
    logic signed [QUAD_W-1:0] h_reg;
    logic signed [QUAD_W-1:0] c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= QUAD_W'(pa[0]) + QUAD_W'(pa[1]) + QUAD_W'(pa[2]);
            h_reg <= QUAD_W'(ph[0]) + QUAD_W'(ph[1]) + QUAD_W'(ph[2]);
            c_reg <= QUAD_W'(pc[0]) + QUAD_W'(pc[1]) + QUAD_W'(pc[2]) - QUAD_W'(prr);
        end
    end

    // discriminant
    logic signed [DISC_W-1:0] hh;
    logic signed [DISC_W-1:0] ac;
    logic [QUAD_W-1:0]        a_d4;
    logic [QUAD_W-1:0]        a_d7;
    logic [QUAD_W-1:0]        h_d6;

    rsi_mul #(.AW(QUAD_W), .BW(QUAD_W)) u_hsq
    (
        .clk (clk), .en (en), .a (h_reg), .b (h_reg), .p (hh)
    );
    rsi_mul #(.AW(QUAD_W), .BW(QUAD_W)) u_ac
    (
        .clk (clk), .en (en), .a (a_reg), .b (c_reg), .p (ac)
    );

    rsi_delay #(.W(QUAD_W), .DEPTH(T4 - T3)) u_dly_a4
    (
        .clk (clk), .en (en), .din (a_reg), .dout (a_d4)
    );
    rsi_delay #(.W(QUAD_W), .DEPTH(T7 - T4)) u_dly_a7
    (
        .clk (clk), .en (en), .din (a_d4), .dout (a_d7)
    );
    rsi_delay #(.W(QUAD_W), .DEPTH(T6 - T3)) u_dly_h6
    (
        .clk (clk), .en (en), .din (h_reg), .dout (h_d6)
    );

    logic signed [DISC_W-1:0] disc_reg;
    logic                     miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_reg <= hh - ac;
            miss_reg <= (a_d4 == '0) || ((hh - ac) < 0);
        end
    end

    logic [ROOT1_W-1:0] s_root;

    rsi_sqrt #(.W(DISC_W)) u_sqrt_disc
    (
        .clk (clk), .en (en), .x (disc_reg), .r (s_root)
    );

    // root numerators
    logic signed [NUM_W-1:0] num_near_reg;
    logic signed [NUM_W-1:0] num_far_reg;
    logic signed [QUAD_W+1:0] hx;
    logic signed [QUAD_W+1:0] sx;

    always_comb
    begin
        hx = (QUAD_W+2)'($signed(h_d6));
        sx = $signed({2'b00, s_root});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_near_reg <= $signed({(-hx - sx), 16'b0});
            num_far_reg  <= $signed({(-hx + sx), 16'b0});
        end
    end

    logic signed [T_W-1:0] t_near;
    logic signed [T_W-1:0] t_far;

    rsi_div #(.NW(NUM_W), .DW(DIVA_W), .QW(NUM_W), .FLOOR(1'b1)) u_div_near
    (
        .clk (clk), .en (en), .n (num_near_reg), .d (a_d7[DIVA_W-1:0]), .q (t_near)
    );
    rsi_div #(.NW(NUM_W), .DW(DIVA_W), .QW(NUM_W), .FLOOR(1'b1)) u_div_far
    (
        .clk (clk), .en (en), .n (num_far_reg), .d (a_d7[DIVA_W-1:0]), .q (t_far)
    );

    logic miss_d8;

    rsi_delay #(.W(1), .DEPTH(T8 - T5)) u_dly_miss
    (
        .clk (clk), .en (en), .din (miss_reg), .dout (miss_d8)
    );

    // root selection
    logic signed [T_W-1:0] min_s;
    logic signed [T_W-1:0] t_sel;
    logic signed [T_W-1:0] t_reg;
    logic                  hit_reg;

    always_comb
    begin
        min_s = $signed({(T_W-RAD_W)'(0), min_dist_reg});
        t_sel = (t_near >= min_s) ? t_near : t_far;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_sel;
            hit_reg <= !miss_d8 && (t_sel >= min_s);
        end
    end

    logic [6*DIFF_W-1:0] geo_pack;
    logic [6*DIFF_W-1:0] geo_d9;
    logic [3*DIFF_W-1:0] diff_d10;

    assign geo_pack = {diff_reg[2], diff_reg[1], diff_reg[0],
                       dir_reg[2], dir_reg[1], dir_reg[0]};

    rsi_delay #(.W(6*DIFF_W), .DEPTH(T9 - T1)) u_dly_geo
    (
        .clk (clk), .en (en), .din (geo_pack), .dout (geo_d9)
    );
    rsi_delay #(.W(3*DIFF_W), .DEPTH(T10 - T9)) u_dly_diff
    (
        .clk (clk), .en (en), .din (geo_d9[6*DIFF_W-1:3*DIFF_W]), .dout (diff_d10)
    );

    logic [DIST_W-1:0] dist_sat;

    assign dist_sat = (t_reg[T_W-1:DIST_W] != '0) ? '1 : t_reg[DIST_W-1:0];

    logic [DIST_W:0] hd_d15;

    rsi_delay #(.W(DIST_W+1), .DEPTH(T15 - T9)) u_dly_hd
    (
        .clk (clk), .en (en), .din ({hit_reg, dist_sat}), .dout (hd_d15)
    );

    // hit point minus center
    logic signed [PROD3_W-1:0] pt [3];
    logic signed [NRM_W-1:0]   nrm_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_m3
        rsi_mul #(.AW(DIFF_W), .BW(T_W)) u_dt
        (
            .clk (clk), .en (en), .a ($signed(geo_d9[DIFF_W*i +: DIFF_W])), .b (t_reg),
            .p (pt[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nrm_reg[i] <= (NRM_W'($signed(diff_d10[DIFF_W*i +: DIFF_W])) <<< 16)
                            + NRM_W'(pt[i]);
            end
        end
    end

    // normal length
    logic signed [NSQ_W-1:0] nsq [3];
    logic [SUM_W-1:0]        sum_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_m4
        rsi_mul #(.AW(NRM_W), .BW(NRM_W)) u_nsq
        (
            .clk (clk), .en (en), .a (nrm_reg[i]), .b (nrm_reg[i]), .p (nsq[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= SUM_W'(nsq[0]) + SUM_W'(nsq[1]) + SUM_W'(nsq[2]);
        end
    end

    logic [LEN_W-1:0] len;

    rsi_sqrt #(.W(SUM_W)) u_sqrt_len
    (
        .clk (clk), .en (en), .x (sum_reg), .r (len)
    );

    logic [3*NRM_W-1:0] nrm_d14;

    rsi_delay #(.W(3*NRM_W), .DEPTH(T14 - T11)) u_dly_nrm
    (
        .clk (clk), .en (en), .din ({nrm_reg[2], nrm_reg[1], nrm_reg[0]}), .dout (nrm_d14)
    );

    logic lz_d15;

    rsi_delay #(.W(1), .DEPTH(T15 - T14)) u_dly_lz
    (
        .clk (clk), .en (en), .din (len == '0), .dout (lz_d15)
    );

    // unit normal
    logic signed [NOUT_W-1:0] nq [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_d2
        rsi_div #(.NW(NDIV_W), .DW(LEN_W), .QW(NQ_W), .FLOOR(1'b0)) u_div_n
        (
            .clk (clk), .en (en),
            .n   ($signed({nrm_d14[NRM_W*i +: NRM_W], 14'b0})),
            .d   (len), .q (nq[i])
        );
    end

    logic                  out_hit_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic [NOUT_W-1:0]     out_n_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg  <= hd_d15[DIST_W];
            out_dist_reg <= hd_d15[DIST_W] ? hd_d15[DIST_W-1:0] : '0;
            for (int i = 0; i < 3; i++)
            begin
                out_n_reg[i] <= (hd_d15[DIST_W] && !lz_d15) ? nq[i] : '0;
            end
        end
    end

    assign m_tuser = out_hit_reg;
    assign m_tdata = {out_n_reg[2], out_n_reg[1], out_n_reg[0], out_dist_reg};

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result carries nonzero data");

    a_hit_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[DIST_W-1:0] >= {1'b0, min_dist_reg})
        else $error("hit distance below minimum");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384
                   && $signed(m_tdata[63:48]) <= 16384 && $signed(m_tdata[63:48]) >= -16384
                   && $signed(m_tdata[79:64]) <= 16384 && $signed(m_tdata[79:64]) >= -16384))
        else $error("normal component out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

[tb/tb_ray_sphere_intersect_core.sv]
// Self-checking testbench for the ray/sphere intersect core with an exact-arithmetic predictor.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect_core;
    import rsi_pkg::*;

    typedef logic signed [511:0] big_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
    } isect_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int    CYCLE_LIMIT  = 600000;
    localparam int    SETTLE       = 400;
    localparam int    MAX_REPORTS  = 10;
    localparam int    ONE          = 32'h0001_0000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [31:0] sphere_ctr [3];
    logic [30:0]        sphere_rad;
    logic [30:0]        sphere_min;

    isect_t pending_hits[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_request = 0;
    int     hold_left = 0;
    int     cycles = 0;
    int     mismatches = 0;
    int     rays_sent = 0;
    int     results_seen = 0;
    int     hits_seen = 0;

    ray_sphere_intersect_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_hits.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic big_t sx(logic signed [31:0] v);
        return v;
    endfunction

    function automatic big_t isqrt_big(big_t x);
        big_t res = 0;
        big_t bitv;
        bitv = big_t'(1) << 300;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic big_t floor_div(big_t n, big_t d);
        big_t q;
        q = n / d;
        if (n < 0 && q * d != n)
            q = q - 1;
        return q;
    endfunction

    function automatic isect_t trace_sphere(logic [IN_W-1:0] ray);
        isect_t r;
        big_t dv [3];
        big_t dd [3];
        big_t nv [3];
        big_t a, h, c, disc, s, t, m, sum, len, rr, q, sat;
        r = '{1'b0, 32'd0, 16'd0, 16'd0, 16'd0};
        a = 0;
        h = 0;
        c = 0;
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = sx(ray[32*i +: 32]) - sx(sphere_ctr[i]);
            dd[i] = sx(ray[32*(i+3) +: 32]);
            a = a + dd[i] * dd[i];
            h = h + dv[i] * dd[i];
            c = c + dv[i] * dv[i];
        end
        rr = sphere_rad;
        c = c - rr * rr;
        disc = h * h - a * c;
        if (a == 0 || disc < 0)
            return r;
        s = isqrt_big(disc);
        m = sphere_min;
        t = floor_div((-h - s) * 65536, a);
        if (t < m)
            t = floor_div((-h + s) * 65536, a);
        if (t < m)
            return r;
        sat = 32'hFFFF_FFFF;
        r.hit = 1'b1;
        r.distance = (t > sat) ? 32'hFFFF_FFFF : t[31:0];
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = dv[i] * 65536 + dd[i] * t;
            sum = sum + nv[i] * nv[i];
        end
        len = isqrt_big(sum);
        if (len == 0)
            return r;
        q = (nv[0] * 16384) / len;
        r.nx = q[15:0];
        q = (nv[1] * 16384) / len;
        r.ny = q[15:0];
        q = (nv[2] * 16384) / len;
        r.nz = q[15:0];
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        return {dz[31:0], dy[31:0], dx[31:0], oz[31:0], oy[31:0], ox[31:0]};
    endfunction

    // receiver: random stalls, plus long holds on request
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        isect_t want;
        isect_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[63:48], m_tdata[79:64]};
            results_seen++;
            if (got.hit)
                hits_seen++;
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transfer: hit=%0b dist=%h", got.hit, got.distance);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp hit=%0b d=%h n=%h/%h/%h  got hit=%0b d=%h n=%h/%h/%h",
                                 want.hit, want.distance, want.nx, want.ny, want.nz,
                                 got.hit, got.distance, got.nx, got.ny, got.nz);
                end
            end
        end
    end

    task automatic send_ray(logic [IN_W-1:0] ray);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ray;
        do
            @(posedge clk);
        while (!s_tready);
        pending_hits.push_back(trace_sphere(ray));
        rays_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_CENTER_X: sphere_ctr[0] = value;
            REG_CENTER_Y: sphere_ctr[1] = value;
            REG_CENTER_Z: sphere_ctr[2] = value;
            REG_RADIUS:   sphere_rad = value[30:0];
            REG_MIN_DIST: sphere_min = value[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(int cx, int cy, int cz, logic [31:0] rad, logic [31:0] mind);
        drain();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_MIN_DIST, mind);
    endtask

    function automatic logic [IN_W-1:0] random_ray();
        logic [IN_W-1:0] ray;
        int off, sh, k;
        if ($urandom_range(99) < 20)
        begin
            for (int i = 0; i < 6; i++)
                ray[32*i +: 32] = $urandom;
            return ray;
        end
        k = $urandom_range(24, 8);
        sh = $urandom_range(4);
        for (int i = 0; i < 3; i++)
        begin
            off = int'($urandom_range((1 << k) - 1)) - (1 << (k - 1));
            ray[32*i +: 32] = sphere_ctr[i] + off;
            ray[32*(i+3) +: 32] = (-off >>> sh) + int'($urandom_range(255)) - 128;
        end
        if ($urandom_range(99) < 3)
            ray[IN_W-1:96] = '0;
        return ray;
    endfunction

    task automatic test_directed_rays();
        // reset values: unit sphere at origin, small epsilon
        send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, ONE));
        send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, 3 * ONE));
        send_ray(pack_ray(0, 0, 0, ONE, ONE, ONE));
        send_ray(pack_ray(0, 0, 5 * ONE, 0, 0, ONE));
        send_ray(pack_ray(ONE, 0, -5 * ONE, 0, 0, ONE));
        send_ray(pack_ray(3 * ONE, 2 * ONE, -ONE, 0, 0, 0));
        send_ray(pack_ray(0, 0, 32'h8000_0000, 0, 0, 1));
        send_ray(pack_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(pack_ray(-1, -1, -1, -1, -1, -1));
        send_ray(pack_ray(0, 0, -3 * ONE, ONE, 0, 0));
        // zero radius: one ray straight through the center, one passing beside it
        set_sphere(0, 0, 0, 0, 66);
        send_ray(pack_ray(-3 * ONE, 0, 0, ONE, 0, 0));
        send_ray(pack_ray(-3 * ONE, ONE, 0, ONE, 0, 0));
    endtask

    task automatic test_register_extremes();
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_ray(pack_ray(0, 0, 0, 0, 0, 0));
        send_ray(pack_ray(0, 0, 0, ONE, -ONE, ONE));
        send_ray(pack_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0));
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5 * ONE, 32'h7FFF_FFFF);
        send_ray(pack_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000 + 10 * ONE, 0, 0, -1));
        send_ray(pack_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000 + 10 * ONE, 0, 0, -ONE));
        drain();
        write_reg(REG_UNUSED, 32'h1234_5678);
        write_reg(REG_MIN_DIST, 32'hFFFF_FFFF);
        send_ray(pack_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000 + 10 * ONE, 0, 0, -1));
    endtask

    task automatic test_backpressure();
        set_sphere(ONE, -2 * ONE, 3 * ONE, 4 * ONE, 66);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 900;
        repeat (360) send_ray(random_ray());
        drain();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
            begin
                if ($urandom_range(3) == 0)
                    set_sphere($urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    set_sphere(int'($urandom_range(1 << 24)) - (1 << 23),
                               int'($urandom_range(1 << 24)) - (1 << 23),
                               int'($urandom_range(1 << 24)) - (1 << 23),
                               $urandom_range(1 << 22),
                               ($urandom_range(1)) ? 0 : $urandom_range(1 << 16));
            end
            send_ray(random_ray());
        end
    endtask

    initial
    begin
        sphere_ctr[0] = 0;
        sphere_ctr[1] = 0;
        sphere_ctr[2] = 0;
        sphere_rad = RADIUS_RESET;
        sphere_min = MIN_DIST_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_rays();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(36, 66, 95);
        test_random_traffic(66, 36, 95);
        test_random_traffic(0, 0, 95);
        drain();
        $display("covered %0d rays (%0d hits) over directed, extreme, stall and random phases",
                 rays_sent, hits_seen);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
